// ===== rtl/skt_pkg.sv =====
// Shared constants and codes for the sorted key table with slot bitmap.
package skt_pkg;

    localparam int ENTRIES_DEF = 256;

    localparam int ACT_W    = 3;
    localparam int KEY_W    = 16;
    localparam int POS_W    = 8;
    localparam int STEP_W   = 14;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 8;
    localparam int SLOT_W   = 8;
    localparam int CNT_W    = 9;
    localparam int LIMIT_W  = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd9999;

    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MOVE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RENUM  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd6;

    localparam logic [STATUS_W-1:0] STAT_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EXISTS       = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL         = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_BAD_INTERVAL = 3'd5;

endpackage

// ===== rtl/skt_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module skt_ram #(
    parameter int DEPTH = skt_pkg::ENTRIES_DEF,
    parameter int WIDTH = skt_pkg::KEY_W,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sorted_key_table_with_slot_bitmap.sv =====
// Sorted key table with slot bitmap: sequencer, table and bitmap memories.
//
// Usage: an input transaction on s_* carries an action and its operands; each
// one yields exactly one result transaction on m_*. The renumber limit is
// written over the cfg_* channel, which is always ready and should only be
// used while no transaction is in flight.
// One operation runs at a time; s_ready is high only while the sequencer is
// idle. All work goes through one table read port and one write port, one
// entry per cycle, and one bitmap bit per cycle:
//   find: binary search for the lower bound, each probe a table read then a compare
//   read: one table read at the given position, checked against count
//   insert: search + free-slot scan (up to ENTRIES) + shift up (up to count)
//   delete: shift down (up to count); move: three searches, shift down and up
//   renumber: one key write per entry; clear: sweep over all ENTRIES bitmap bits
// After reset the bitmap is cleared in a sweep over all ENTRIES bits with s_ready
// low. A finished result waits in the output register; while the receiver
// stalls, the next transaction is accepted and processed, and its result is
// held until the previous one is taken.
module sorted_key_table_with_slot_bitmap #(
    parameter int ENTRIES = skt_pkg::ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [skt_pkg::LIMIT_W-1:0]   cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [skt_pkg::ACT_W-1:0]     s_action,
    input  logic [skt_pkg::KEY_W-1:0]     s_key,
    input  logic [skt_pkg::KEY_W-1:0]     s_new_key,
    input  logic [skt_pkg::POS_W-1:0]     s_position,
    input  logic [skt_pkg::STEP_W-1:0]    s_step_size,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [skt_pkg::STATUS_W-1:0]  m_status,
    output logic [skt_pkg::IDX_W-1:0]     m_found_index,
    output logic [skt_pkg::SLOT_W-1:0]    m_slot,
    output logic [skt_pkg::KEY_W-1:0]     m_entry_key,
    output logic [skt_pkg::CNT_W-1:0]     m_entry_count,
    output logic [skt_pkg::KEY_W-1:0]     m_first_key,
    output logic [skt_pkg::KEY_W-1:0]     m_last_key
);

    import skt_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int OW = (CW > CNT_W) ? CW : CNT_W;
    localparam int PW = CW + STEP_W;

    localparam logic [4:0] SQ_BOOT     = 5'd0;
    localparam logic [4:0] SQ_IDLE     = 5'd1;
    localparam logic [4:0] SQ_DISP     = 5'd2;
    localparam logic [4:0] SQ_LB       = 5'd3;
    localparam logic [4:0] SQ_LB_CMP   = 5'd4;
    localparam logic [4:0] SQ_LB_CHK   = 5'd5;
    localparam logic [4:0] SQ_FREE     = 5'd6;
    localparam logic [4:0] SQ_UP       = 5'd7;
    localparam logic [4:0] SQ_INS      = 5'd8;
    localparam logic [4:0] SQ_POS_CHK  = 5'd9;
    localparam logic [4:0] SQ_DN       = 5'd10;
    localparam logic [4:0] SQ_REN_CHK  = 5'd11;
    localparam logic [4:0] SQ_REN      = 5'd12;
    localparam logic [4:0] SQ_CLR      = 5'd13;
    localparam logic [4:0] SQ_EDGE     = 5'd14;
    localparam logic [4:0] SQ_EDGE1    = 5'd15;
    localparam logic [4:0] SQ_EDGE2    = 5'd16;
    localparam logic [4:0] SQ_FIN      = 5'd17;

    localparam logic [1:0] PH_DST = 2'd0;
    localparam logic [1:0] PH_SRC = 2'd1;
    localparam logic [1:0] PH_INS = 2'd2;

    logic [4:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    nkey_reg, nkey_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [1:0]          phase_reg, phase_next;
    logic [KEY_W-1:0]    tgt_reg, tgt_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       i_reg, i_next;
    logic                pend_reg, pend_next;
    logic [IW-1:0]       wdst_reg, wdst_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       new_slot_reg, new_slot_next;
    logic [IW-1:0]       fr_addr_reg, fr_addr_next;
    logic [IW-1:0]       fr_chk_reg, fr_chk_next;
    logic                fr_pend_reg, fr_pend_next;
    logic [IW-1:0]       clr_addr_reg, clr_addr_next;
    logic [KEY_W-1:0]    acc_reg, acc_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IW-1:0]       res_idx_reg, res_idx_next;
    logic [IW-1:0]       res_slot_reg, res_slot_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [KEY_W-1:0]    res_first_reg, res_first_next;
    logic [KEY_W-1:0]    res_last_reg, res_last_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic [KEY_W-1:0]    m_key_reg, m_key_next;
    logic [CNT_W-1:0]    m_cnt_reg, m_cnt_next;
    logic [KEY_W-1:0]    m_first_reg, m_first_next;
    logic [KEY_W-1:0]    m_last_reg, m_last_next;

    logic [IW-1:0]       tbl_raddr, tbl_waddr;
    logic                key_we, slot_we;
    logic [KEY_W-1:0]    key_wdata, key_rdata;
    logic [IW-1:0]       slot_wdata, slot_rdata;
    logic [IW-1:0]       bm_raddr, bm_waddr;
    logic                bm_we;
    logic [0:0]          bm_wdata, bm_rdata;

    logic [CW-1:0]       mid_w, lo_inc, i_inc, i_dec, cnt_dec;
    logic [OW-1:0]       pos_ow, cnt_ow, idx_ow, slot_ow;

    assign mid_w   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_inc  = lo_reg + CW'(1);
    assign i_inc   = i_reg + CW'(1);
    assign i_dec   = i_reg - CW'(1);
    assign cnt_dec = count_reg - CW'(1);
    assign pos_ow  = OW'(pos_reg);
    assign cnt_ow  = OW'(count_reg);
    assign idx_ow  = OW'(res_idx_reg);
    assign slot_ow = OW'(res_slot_reg);

    skt_ram #(.DEPTH(ENTRIES), .WIDTH(KEY_W)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (tbl_waddr),
        .wdata (key_wdata),
        .raddr (tbl_raddr),
        .rdata (key_rdata)
    );

    skt_ram #(.DEPTH(ENTRIES), .WIDTH(IW)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (tbl_waddr),
        .wdata (slot_wdata),
        .raddr (tbl_raddr),
        .rdata (slot_rdata)
    );

    skt_ram #(.DEPTH(ENTRIES), .WIDTH(1)) u_bitmap_ram (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    always_comb begin
        logic hit;
        hit             = 1'b0;
        state_next      = state_reg;
        count_next      = count_reg;
        limit_next      = limit_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        nkey_next       = nkey_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        phase_next      = phase_reg;
        tgt_next        = tgt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        i_next          = i_reg;
        pend_next       = pend_reg;
        wdst_next       = wdst_reg;
        idx_next        = idx_reg;
        new_slot_next   = new_slot_reg;
        fr_addr_next    = fr_addr_reg;
        fr_chk_next     = fr_chk_reg;
        fr_pend_next    = fr_pend_reg;
        clr_addr_next   = clr_addr_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_slot_next   = res_slot_reg;
        res_key_next    = res_key_reg;
        res_first_next  = res_first_reg;
        res_last_next   = res_last_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_idx_next      = m_idx_reg;
        m_slot_next     = m_slot_reg;
        m_key_next      = m_key_reg;
        m_cnt_next      = m_cnt_reg;
        m_first_next    = m_first_reg;
        m_last_next     = m_last_reg;

        tbl_raddr  = '0;
        tbl_waddr  = wdst_reg;
        key_we     = 1'b0;
        slot_we    = 1'b0;
        key_wdata  = key_rdata;
        slot_wdata = slot_rdata;
        bm_raddr   = fr_addr_reg;
        bm_waddr   = clr_addr_reg;
        bm_we      = 1'b0;
        bm_wdata   = 1'b0;

        if (cfg_valid) begin
            limit_next = cfg_wdata;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg) inside
            SQ_BOOT, SQ_CLR: begin
                bm_we         = 1'b1;
                clr_addr_next = clr_addr_reg + IW'(1);
                if (clr_addr_reg == IW'(ENTRIES - 1)) begin
                    state_next = (state_reg == SQ_BOOT) ? SQ_IDLE : SQ_EDGE;
                end
            end
            SQ_IDLE: begin
                if (s_valid) begin
                    act_next        = s_action;
                    key_next        = s_key;
                    nkey_next       = s_new_key;
                    pos_next        = s_position;
                    step_next       = s_step_size;
                    res_status_next = STAT_OK;
                    res_idx_next    = '0;
                    res_slot_next   = '0;
                    res_key_next    = '0;
                    state_next      = SQ_DISP;
                end
            end
            SQ_DISP: begin
                lo_next    = '0;
                hi_next    = count_reg;
                phase_next = PH_DST;
                unique case (act_reg) inside
                    ACT_FIND, ACT_INSERT: begin
                        tgt_next   = key_reg;
                        state_next = SQ_LB;
                    end
                    ACT_MOVE: begin
                        tgt_next   = nkey_reg;
                        state_next = SQ_LB;
                    end
                    ACT_DELETE, ACT_READ: begin
                        if (pos_ow >= cnt_ow) begin
                            res_status_next = STAT_BAD_INDEX;
                            state_next      = SQ_EDGE;
                        end else begin
                            tbl_raddr  = pos_ow[IW-1:0];
                            idx_next   = pos_ow[IW-1:0];
                            state_next = SQ_POS_CHK;
                        end
                    end
                    ACT_RENUM: begin
                        prod_next  = PW'(count_reg) * PW'(step_reg);
                        state_next = SQ_REN_CHK;
                    end
                    ACT_CLEAR: begin
                        count_next    = '0;
                        clr_addr_next = '0;
                        state_next    = SQ_CLR;
                    end
                    default: begin
                        state_next = SQ_EDGE;
                    end
                endcase
            end
            SQ_LB: begin
                if (lo_reg < hi_reg) begin
                    tbl_raddr  = mid_w[IW-1:0];
                    mid_next   = mid_w;
                    state_next = SQ_LB_CMP;
                end else begin
                    tbl_raddr  = lo_reg[IW-1:0];
                    state_next = SQ_LB_CHK;
                end
            end
            SQ_LB_CMP: begin
                if (key_rdata < tgt_reg) begin
                    lo_next = mid_reg + CW'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = SQ_LB;
            end
            SQ_LB_CHK: begin
                hit        = (lo_reg < count_reg) && (key_rdata == tgt_reg);
                idx_next   = lo_reg[IW-1:0];
                state_next = SQ_EDGE;
                case (act_reg) inside
                    ACT_FIND, ACT_INSERT: begin
                        if (hit) begin
                            res_idx_next  = lo_reg[IW-1:0];
                            res_slot_next = slot_rdata;
                            res_key_next  = tgt_reg;
                        end else if (act_reg == ACT_FIND) begin
                            res_status_next = STAT_NOT_FOUND;
                        end else if (count_reg == CW'(ENTRIES)) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            fr_addr_next = '0;
                            fr_pend_next = 1'b0;
                            state_next   = SQ_FREE;
                        end
                    end
                    ACT_MOVE: begin
                        case (phase_reg)
                            PH_DST: begin
                                if (hit) begin
                                    res_status_next = STAT_EXISTS;
                                end else begin
                                    phase_next = PH_SRC;
                                    tgt_next   = key_reg;
                                    lo_next    = '0;
                                    hi_next    = count_reg;
                                    state_next = SQ_LB;
                                end
                            end
                            PH_SRC: begin
                                if (!hit) begin
                                    res_status_next = STAT_NOT_FOUND;
                                end else begin
                                    new_slot_next = slot_rdata;
                                    i_next        = lo_inc;
                                    pend_next     = 1'b0;
                                    state_next    = SQ_DN;
                                end
                            end
                            default: begin
                                i_next     = count_reg;
                                pend_next  = 1'b0;
                                state_next = SQ_UP;
                            end
                        endcase
                    end
                    default: begin
                        state_next = SQ_EDGE;
                    end
                endcase
            end
            SQ_FREE: begin
                fr_addr_next = fr_addr_reg + IW'(1);
                fr_chk_next  = fr_addr_reg;
                fr_pend_next = 1'b1;
                if (fr_pend_reg) begin
                    if (!bm_rdata[0]) begin
                        bm_we         = 1'b1;
                        bm_waddr      = fr_chk_reg;
                        bm_wdata      = 1'b1;
                        new_slot_next = fr_chk_reg;
                        i_next        = count_reg;
                        pend_next     = 1'b0;
                        state_next    = SQ_UP;
                    end else if (fr_chk_reg == IW'(ENTRIES - 1)) begin
                        res_status_next = STAT_FULL;
                        state_next      = SQ_EDGE;
                    end
                end
            end
            SQ_UP: begin
                if (pend_reg) begin
                    key_we  = 1'b1;
                    slot_we = 1'b1;
                end
                if (i_reg > CW'(idx_reg)) begin
                    tbl_raddr = i_dec[IW-1:0];
                    wdst_next = i_reg[IW-1:0];
                    i_next    = i_dec;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = SQ_INS;
                    end
                end
            end
            SQ_INS: begin
                key_we        = 1'b1;
                slot_we       = 1'b1;
                tbl_waddr     = idx_reg;
                key_wdata     = tgt_reg;
                slot_wdata    = new_slot_reg;
                count_next    = count_reg + CW'(1);
                res_idx_next  = idx_reg;
                res_slot_next = new_slot_reg;
                res_key_next  = tgt_reg;
                state_next    = SQ_EDGE;
            end
            SQ_POS_CHK: begin
                res_idx_next  = idx_reg;
                res_slot_next = slot_rdata;
                res_key_next  = key_rdata;
                if (act_reg == ACT_DELETE) begin
                    bm_we      = 1'b1;
                    bm_waddr   = slot_rdata;
                    bm_wdata   = 1'b0;
                    i_next     = CW'(idx_reg) + CW'(1);
                    pend_next  = 1'b0;
                    state_next = SQ_DN;
                end else begin
                    state_next = SQ_EDGE;
                end
            end
            SQ_DN: begin
                if (pend_reg) begin
                    key_we  = 1'b1;
                    slot_we = 1'b1;
                end
                if (i_reg < count_reg) begin
                    tbl_raddr = i_reg[IW-1:0];
                    wdst_next = i_dec[IW-1:0];
                    i_next    = i_inc;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = cnt_dec;
                        if (act_reg == ACT_MOVE) begin
                            phase_next = PH_INS;
                            tgt_next   = nkey_reg;
                            lo_next    = '0;
                            hi_next    = cnt_dec;
                            state_next = SQ_LB;
                        end else begin
                            state_next = SQ_EDGE;
                        end
                    end
                end
            end
            SQ_REN_CHK: begin
                if (step_reg == '0 || prod_reg > PW'(limit_reg)) begin
                    res_status_next = STAT_BAD_INTERVAL;
                    state_next      = SQ_EDGE;
                end else begin
                    i_next     = '0;
                    acc_next   = KEY_W'(step_reg);
                    state_next = SQ_REN;
                end
            end
            SQ_REN: begin
                if (i_reg < count_reg) begin
                    key_we    = 1'b1;
                    tbl_waddr = i_reg[IW-1:0];
                    key_wdata = acc_reg;
                    acc_next  = acc_reg + KEY_W'(step_reg);
                    i_next    = i_inc;
                end else begin
                    state_next = SQ_EDGE;
                end
            end
            SQ_EDGE: begin
                if (count_reg == '0) begin
                    res_first_next = '0;
                    res_last_next  = '0;
                    state_next     = SQ_FIN;
                end else begin
                    tbl_raddr  = '0;
                    state_next = SQ_EDGE1;
                end
            end
            SQ_EDGE1: begin
                res_first_next = key_rdata;
                tbl_raddr      = cnt_dec[IW-1:0];
                state_next     = SQ_EDGE2;
            end
            SQ_EDGE2: begin
                res_last_next = key_rdata;
                state_next    = SQ_FIN;
            end
            SQ_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_idx_next    = idx_ow[IDX_W-1:0];
                    m_slot_next   = slot_ow[SLOT_W-1:0];
                    m_key_next    = res_key_reg;
                    m_cnt_next    = cnt_ow[CNT_W-1:0];
                    m_first_next  = res_first_reg;
                    m_last_next   = res_last_reg;
                    state_next    = SQ_IDLE;
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SQ_BOOT;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            fr_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            clr_addr_reg  <= clr_addr_next;
            pend_reg      <= pend_next;
            fr_pend_reg   <= fr_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        nkey_reg       <= nkey_next;
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        phase_reg      <= phase_next;
        tgt_reg        <= tgt_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        i_reg          <= i_next;
        wdst_reg       <= wdst_next;
        idx_reg        <= idx_next;
        new_slot_reg   <= new_slot_next;
        fr_addr_reg    <= fr_addr_next;
        fr_chk_reg     <= fr_chk_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_slot_reg   <= res_slot_next;
        res_key_reg    <= res_key_next;
        res_first_reg  <= res_first_next;
        res_last_reg   <= res_last_next;
        m_status_reg   <= m_status_next;
        m_idx_reg      <= m_idx_next;
        m_slot_reg     <= m_slot_next;
        m_key_reg      <= m_key_next;
        m_cnt_reg      <= m_cnt_next;
        m_first_reg    <= m_first_next;
        m_last_reg     <= m_last_next;
    end

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == SQ_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_index = m_idx_reg;
    assign m_slot        = m_slot_reg;
    assign m_entry_key   = m_key_reg;
    assign m_entry_count = m_cnt_reg;
    assign m_first_key   = m_first_reg;
    assign m_last_key    = m_last_reg;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("transaction accepted while an operation is in progress");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == SQ_FIN))
        else $error("result presented outside the finish step");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_INS) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the entry count by one");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_INS) |-> (count_reg < CW'(ENTRIES)))
        else $error("insert into a full table");

endmodule
